// ----- sv/ehist_pkg.sv -----
// Shared types, constants and state encodings for the equal-width histogram.
// No dependencies; every other file imports this package.
package ehist_pkg;

    localparam int MAX_BINS      = 64;
    localparam int IDX_BITS      = 6;
    localparam int COUNT_BITS    = 32;
    localparam int SAMPLE_BITS   = 10;
    localparam int WIDTH_BITS    = 11;
    localparam int NBINS_BITS    = 7;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 11;
    localparam int STEP_BITS     = $clog2(SAMPLE_BITS);
    // queue depth must be a power of two
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_BITS-1:0] CFG_LOW_BOUND = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BIN_WIDTH = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NUM_BINS  = 2'd2;

    localparam logic [SAMPLE_BITS-1:0] RESET_LOW_BOUND = 10'd1;
    localparam logic [WIDTH_BITS-1:0]  RESET_BIN_WIDTH = 11'd100;
    localparam logic [NBINS_BITS-1:0]  RESET_NUM_BINS  = 7'd10;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef enum logic {
        CMD_ADD  = 1'b0,
        CMD_READ = 1'b1
    } cmd_t;

    typedef struct packed {
        logic                   command;
        logic [SAMPLE_BITS-1:0] sample;
        logic [IDX_BITS-1:0]    bin_select;
    } in_item_t;

    typedef struct packed {
        logic [IDX_BITS-1:0]   bin_index;
        logic [COUNT_BITS-1:0] count;
        logic                  in_range;
    } out_item_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] low_bound;
        logic [WIDTH_BITS-1:0]  bin_width;
        logic [NBINS_BITS-1:0]  num_bins;
    } cfg_t;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_READ,
        OP_MISS
    } op_kind_t;

    typedef struct packed {
        op_kind_t            kind;
        logic [IDX_BITS-1:0] index;
    } op_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_SEND
    } front_state_t;

    typedef enum logic {
        B_IDLE,
        B_CALC
    } back_state_t;

endpackage

// ----- sv/ehist_front.sv -----
// Front end: takes requests, divides by the bin width one bit a cycle, classifies.
// Depends on ehist_pkg.
module ehist_front (
    input  logic                clk,
    input  logic                rst_n,
    input  ehist_pkg::cfg_t     cfg,
    input  logic                push,
    output logic                full,
    input  ehist_pkg::in_item_t request,
    output logic                q_push,
    input  logic                q_full,
    output ehist_pkg::op_t      q_wdata
);
    import ehist_pkg::*;

    front_state_t            state_reg, state_next;
    op_t                     op_reg, op_next;
    logic [SAMPLE_BITS-1:0]  dvd_reg, dvd_next;
    logic [WIDTH_BITS-1:0]   rem_reg, rem_next;
    logic [STEP_BITS-1:0]    step_reg, step_next;
    logic [NBINS_BITS-1:0]   used;
    logic [WIDTH_BITS:0]     shifted;
    logic [WIDTH_BITS-1:0]   diff;
    logic                    ge;
    logic [SAMPLE_BITS-1:0]  quot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        step_reg <= step_next;
    end

    always_comb
    begin
        used = (cfg.num_bins > NBINS_BITS'(MAX_BINS)) ? NBINS_BITS'(MAX_BINS) : cfg.num_bins;
        shifted = {rem_reg, dvd_reg[SAMPLE_BITS-1]};
        ge      = shifted >= {1'b0, cfg.bin_width};
        // remainder stays below the bin width, so the low bits are enough
        diff    = shifted[WIDTH_BITS-1:0] - cfg.bin_width;
        quot    = {dvd_reg[SAMPLE_BITS-2:0], ge};

        state_next = state_reg;
        op_next    = op_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        step_next  = step_reg;
        full       = 1'b1;
        q_push     = 1'b0;
        q_wdata    = op_reg;

        unique case (state_reg)
            F_IDLE:
            begin
                full = 1'b0;
                if (push)
                begin
                    if (request.command == CMD_READ)
                    begin
                        op_next.index = request.bin_select;
                        op_next.kind  = (NBINS_BITS'(request.bin_select) < used) ?
                                        OP_READ : OP_MISS;
                        state_next    = F_SEND;
                    end
                    else if (cfg.bin_width == '0 || request.sample < cfg.low_bound)
                    begin
                        op_next.kind  = OP_MISS;
                        op_next.index = '0;
                        state_next    = F_SEND;
                    end
                    else
                    begin
                        dvd_next   = request.sample - cfg.low_bound;
                        rem_next   = '0;
                        step_next  = STEP_BITS'(SAMPLE_BITS - 1);
                        state_next = F_DIV;
                    end
                end
            end
            F_DIV:
            begin
                rem_next  = ge ? diff : shifted[WIDTH_BITS-1:0];
                dvd_next  = quot;
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    if (quot < SAMPLE_BITS'(used))
                    begin
                        op_next.kind  = OP_ADD;
                        op_next.index = quot[IDX_BITS-1:0];
                    end
                    else
                    begin
                        op_next.kind  = OP_MISS;
                        op_next.index = '0;
                    end
                    state_next = F_SEND;
                end
            end
            F_SEND:
            begin
                q_push = 1'b1;
                if (!q_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/ehist_fifo.sv -----
// Short queue of classified requests between front and back ends.
// Depends on ehist_pkg.
module ehist_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr,
    output logic           full,
    input  ehist_pkg::op_t wdata,
    input  logic           rd,
    output logic           empty,
    output ehist_pkg::op_t rdata
);
    import ehist_pkg::*;

    op_t                  slot_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wp_reg, wp_next;
    logic [QPTR_BITS-1:0] rp_reg, rp_next;
    logic [QCNT_BITS-1:0] cnt_reg, cnt_next;
    logic                 do_wr;
    logic                 do_rd;

    always_comb
    begin
        full  = cnt_reg == QCNT_BITS'(QUEUE_DEPTH);
        empty = cnt_reg == '0;
        rdata = slot_reg[rp_reg];
        do_wr = wr && !full;
        do_rd = rd && !empty;
        wp_next  = do_wr ? wp_reg + 1'b1 : wp_reg;
        rp_next  = do_rd ? rp_reg + 1'b1 : rp_reg;
        cnt_next = cnt_reg + QCNT_BITS'(do_wr) - QCNT_BITS'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wp_reg] <= wdata;
        end
    end

endmodule

// ----- sv/ehist_back.sv -----
// Back end: count memory with read-modify-write, saturating increment, result register.
// Depends on ehist_pkg.
module ehist_back (
    input  logic                 clk,
    input  logic                 rst_n,
    output logic                 q_pop,
    input  logic                 q_empty,
    input  ehist_pkg::op_t       q_rdata,
    output logic                 empty,
    input  logic                 pop,
    output ehist_pkg::out_item_t result
);
    import ehist_pkg::*;

    logic [COUNT_BITS-1:0] mem [MAX_BINS];
    logic [MAX_BINS-1:0]   vld_reg;
    logic [COUNT_BITS-1:0] rd_reg;
    back_state_t           state_reg, state_next;
    op_t                   op_reg, op_next;
    out_item_t             out_reg, out_next;
    logic                  out_vld_reg, out_vld_next;
    logic [COUNT_BITS-1:0] cur;
    logic [COUNT_BITS-1:0] inc;
    logic                  load;
    logic                  wr;

    always_comb
    begin
        cur = vld_reg[op_reg.index] ? rd_reg : '0;
        inc = (cur == COUNT_MAX) ? cur : cur + 1'b1;

        state_next = state_reg;
        op_next    = op_reg;
        q_pop      = 1'b0;
        load       = 1'b0;
        wr         = 1'b0;
        out_next   = out_reg;

        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    op_next    = q_rdata;
                    state_next = B_CALC;
                end
            end
            B_CALC:
            begin
                if (!out_vld_reg || pop)
                begin
                    load       = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase

        if (load)
        begin
            out_next.bin_index = op_reg.index;
            unique case (op_reg.kind)
                OP_ADD:
                begin
                    wr                = 1'b1;
                    out_next.count    = inc;
                    out_next.in_range = 1'b1;
                end
                OP_READ:
                begin
                    out_next.count    = cur;
                    out_next.in_range = 1'b1;
                end
                default:
                begin
                    out_next.count    = '0;
                    out_next.in_range = 1'b0;
                end
            endcase
        end

        out_vld_next = (out_vld_reg && !pop) || load;
        empty        = !out_vld_reg;
        result       = out_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= B_IDLE;
            out_vld_reg <= 1'b0;
            vld_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
            if (wr)
            begin
                vld_reg[op_reg.index] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        out_reg <= out_next;
        if (q_pop)
        begin
            rd_reg <= mem[q_rdata.index];
        end
        if (wr)
        begin
            mem[op_reg.index] <= inc;
        end
    end

endmodule

// ----- sv/equal_width_histogram.sv -----
// Top level of the equal-width histogram: configuration registers and the
// front end, queue and back end. Depends on ehist_pkg, ehist_front, ehist_fifo, ehist_back.
//
// Requests enter through a queue-style push/full port and results leave through
// empty/pop. An add request occupies the front end while the one-bit-per-cycle
// divider forms the bin index and until the queue takes the result; a read request
// occupies it until the queue takes it. The back end reads and writes back the count
// memory for one request at a time, and a two-entry queue plus a result register let
// either side stall without holding up the other. Counters read as zero after reset
// through per-bin valid bits, so no clearing pass is needed. The user must write
// configuration with cfg_we/cfg_index/cfg_data only while the block is idle; unenforced.
module equal_width_histogram (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [ehist_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [ehist_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                  push,
    output logic                                  full,
    input  ehist_pkg::in_item_t                   request,
    output logic                                  empty,
    input  logic                                  pop,
    output ehist_pkg::out_item_t                  result
);
    import ehist_pkg::*;

    cfg_t cfg_reg;
    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;
    op_t  q_wdata;
    op_t  q_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.low_bound <= RESET_LOW_BOUND;
            cfg_reg.bin_width <= RESET_BIN_WIDTH;
            cfg_reg.num_bins  <= RESET_NUM_BINS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LOW_BOUND: cfg_reg.low_bound <= cfg_data[SAMPLE_BITS-1:0];
                CFG_BIN_WIDTH: cfg_reg.bin_width <= cfg_data[WIDTH_BITS-1:0];
                CFG_NUM_BINS:  cfg_reg.num_bins  <= cfg_data[NBINS_BITS-1:0];
                default:       cfg_reg           <= cfg_reg;
            endcase
        end
    end

    ehist_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .push    (push),
        .full    (full),
        .request (request),
        .q_push  (q_push),
        .q_full  (q_full),
        .q_wdata (q_wdata)
    );

    ehist_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (q_push),
        .full  (q_full),
        .wdata (q_wdata),
        .rd    (q_pop),
        .empty (q_empty),
        .rdata (q_rdata)
    );

    ehist_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_pop   (q_pop),
        .q_empty (q_empty),
        .q_rdata (q_rdata),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

// ----- sv/ehist_check.sv -----
// Port-level checks for equal_width_histogram, bound to the top level.
// Depends on ehist_pkg and equal_width_histogram.
module ehist_check (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 push,
    input logic                 full,
    input logic                 empty,
    input logic                 pop,
    input ehist_pkg::out_item_t result
);
    import ehist_pkg::*;

    // front end is busy in the cycle after taking a request
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        push && !full |=> full)
        else $error("full not raised after accepted request");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(result))
        else $error("waiting result changed");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !result.in_range |-> result.count == '0)
        else $error("out-of-range result carries a count");

endmodule

bind equal_width_histogram ehist_check u_check (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .full   (full),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);

// ----- sim/equal_width_histogram_test.sv -----
// Self-checking testbench for equal_width_histogram: directed and random requests
// under random idling on both sides, checked against a bin-count scoreboard.
// Depends on ehist_pkg and equal_width_histogram.
module equal_width_histogram_test;
    import ehist_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 40;

    class hist_scoreboard;
        logic [COUNT_BITS-1:0]  bin_count [MAX_BINS];
        logic [SAMPLE_BITS-1:0] low_bound;
        logic [WIDTH_BITS-1:0]  bin_width;
        logic [NBINS_BITS-1:0]  num_bins;
        out_item_t              expected_q [$];
        int                     errors;
        int                     checked;
        int                     adds;
        int                     misses;
        int                     reads;
        int                     settings;

        function new();
            foreach (bin_count[i])
                bin_count[i] = '0;
            low_bound = RESET_LOW_BOUND;
            bin_width = RESET_BIN_WIDTH;
            num_bins  = RESET_NUM_BINS;
            errors    = 0;
            checked   = 0;
            adds      = 0;
            misses    = 0;
            reads     = 0;
            settings  = 1;
        endfunction

        function int bins_used();
            return (num_bins > MAX_BINS) ? MAX_BINS : int'(num_bins);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void set_register(logic [CFG_IDX_BITS-1:0] idx,
                                   logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                CFG_LOW_BOUND: low_bound = data[SAMPLE_BITS-1:0];
                CFG_BIN_WIDTH: bin_width = data[WIDTH_BITS-1:0];
                CFG_NUM_BINS:  num_bins  = data[NBINS_BITS-1:0];
                default: ;
            endcase
        endfunction

        function void note_request(in_item_t req);
            out_item_t res;
            int        used;
            int        bin;
            used = bins_used();
            res  = '0;
            if (req.command == CMD_READ) begin
                reads++;
                res.bin_index = req.bin_select;
                if (int'(req.bin_select) < used) begin
                    res.count    = bin_count[req.bin_select];
                    res.in_range = 1'b1;
                end
            end else begin
                adds++;
                bin = -1;
                if (bin_width != 0 && req.sample >= low_bound)
                    bin = (int'(req.sample) - int'(low_bound)) / int'(bin_width);
                if (bin >= 0 && bin < used) begin
                    if (bin_count[bin] != COUNT_MAX)
                        bin_count[bin] = bin_count[bin] + 1'b1;
                    res.bin_index = bin[IDX_BITS-1:0];
                    res.count     = bin_count[bin];
                    res.in_range  = 1'b1;
                end else begin
                    misses++;
                end
            end
            expected_q.push_back(res);
        endfunction

        function void check_result(out_item_t got);
            out_item_t exp;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result: bin %0d count %0d in_range %0d",
                         $time, got.bin_index, got.count, got.in_range);
                errors++;
                return;
            end
            exp = expected_q.pop_front();
            checked++;
            if (got.bin_index !== exp.bin_index || got.count !== exp.count ||
                got.in_range !== exp.in_range) begin
                $display("%0t: mismatch: expected bin %0d count %0d in_range %0d, got bin %0d count %0d in_range %0d",
                         $time, exp.bin_index, exp.count, exp.in_range,
                         got.bin_index, got.count, got.in_range);
                errors++;
            end
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;
    logic                     push = 1'b0;
    logic                     full;
    in_item_t                 request = '0;
    logic                     empty;
    logic                     pop = 1'b0;
    out_item_t                result;

    hist_scoreboard sb = new();
    bit             steady = 1'b0;
    int             stalled = 0;

    equal_width_histogram uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .request   (request),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        pop <= steady || ($urandom_range(0, 99) >= 6);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
                sb.note_request(request);
            if (pop && !empty)
                sb.check_result(result);
            if ((push && !full) || (pop && !empty))
                stalled <= 0;
            else if (stalled >= STALL_LIMIT)
            begin
                $display("%0t: no request or result moved for %0d cycles", $time, stalled);
                $display("Verification failed");
                $finish;
            end
            else
                stalled <= stalled + 1;
        end
    end

    task automatic send(input in_item_t r);
        if (!steady && $urandom_range(0, 99) < 6)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        push    <= 1'b1;
        request <= r;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic configure(input int lb, input int bw, input int nb);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_LOW_BOUND;
        cfg_data  <= CFG_DATA_BITS'(lb);
        sb.set_register(CFG_LOW_BOUND, CFG_DATA_BITS'(lb));
        @(posedge clk);
        cfg_index <= CFG_BIN_WIDTH;
        cfg_data  <= CFG_DATA_BITS'(bw);
        sb.set_register(CFG_BIN_WIDTH, CFG_DATA_BITS'(bw));
        @(posedge clk);
        cfg_index <= CFG_NUM_BINS;
        cfg_data  <= CFG_DATA_BITS'(nb);
        sb.set_register(CFG_NUM_BINS, CFG_DATA_BITS'(nb));
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.settings++;
    endtask

    task automatic add(input int s);
        in_item_t r;
        r.command    = CMD_ADD;
        r.sample     = SAMPLE_BITS'(s);
        r.bin_select = IDX_BITS'($urandom_range(0, 63));
        send(r);
    endtask

    task automatic read(input int b);
        in_item_t r;
        r.command    = CMD_READ;
        r.sample     = SAMPLE_BITS'($urandom_range(0, 1023));
        r.bin_select = IDX_BITS'(b);
        send(r);
    endtask

    function automatic in_item_t random_request();
        in_item_t r;
        int       used;
        int       lim;
        used         = sb.bins_used();
        r.command    = CMD_ADD;
        r.sample     = SAMPLE_BITS'($urandom_range(0, 1023));
        r.bin_select = IDX_BITS'($urandom_range(0, 63));
        if ($urandom_range(0, 99) < 25)
        begin
            r.command = CMD_READ;
            if (used > 0 && $urandom_range(0, 3) != 0)
                r.bin_select = IDX_BITS'($urandom_range(0, used - 1));
        end
        else if ($urandom_range(0, 99) < 80 && sb.bin_width != 0)
        begin
            lim = used * int'(sb.bin_width) - 1;
            if (lim > 1023 - int'(sb.low_bound))
                lim = 1023 - int'(sb.low_bound);
            if (lim >= 0)
                r.sample = SAMPLE_BITS'(int'(sb.low_bound) + $urandom_range(0, lim));
        end
        return r;
    endfunction

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // power-up settings: ten bins of 100 from 1
        add(0);
        add(1);
        add(100);
        add(101);
        add(1000);
        add(1001);
        add(1023);
        read(0);
        read(9);
        read(10);
        read(63);
        // unit-width bins, all 64 in use
        configure(0, 1, 64);
        add(0);
        add(63);
        add(64);
        read(63);
        // widest bins, bin count above the maximum
        configure(1023, 2047, 127);
        add(1022);
        add(1023);
        read(0);
        read(63);
        // zero bin width
        configure(5, 0, 10);
        add(5);
        add(1023);
        read(3);
        // no bins in use
        configure(0, 1024, 0);
        add(0);
        read(0);

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: configure(0, 1, 64);
                1: configure($urandom_range(0, 200), $urandom_range(1, 30), $urandom_range(1, 64));
                2: configure($urandom_range(0, 1023), 2047, 127);
                3: configure($urandom_range(0, 100), $urandom_range(1, 16), 64);
                4: configure($urandom_range(0, 500), $urandom_range(1, 200), $urandom_range(1, 64));
                default: configure($urandom_range(0, 50), $urandom_range(1, 20), 3);
            endcase
            steady = (ph == 3);
            for (int i = 0; i < 100; i++)
            begin
                if (ph == 4 && i == 50)
                    drain();
                send(random_request());
            end
            steady = 1'b0;
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, sb.pending());
            sb.errors++;
        end
        $display("Ran %0d adds (%0d outside every bin) and %0d reads over %0d settings;",
                 sb.adds, sb.misses, sb.reads, sb.settings);
        $display("%0d results compared, %0d mismatches.", sb.checked, sb.errors);
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

// ----- filelist.f -----
sv/ehist_pkg.sv
sv/ehist_front.sv
sv/ehist_fifo.sv
sv/ehist_back.sv
sv/equal_width_histogram.sv
sv/ehist_check.sv
sim/equal_width_histogram_test.sv
